@@ rtl/eatc_pkg.sv @@
`timescale 1ns / 1ps
// eatc_pkg: shared constants, register indexes and result type
// for the episode alarm tone controller; no dependencies
package eatc_pkg;

    localparam int EPISODE_BITS = 32;
    localparam int TIMER_BITS   = 21;
    localparam int CMP_W        = (TIMER_BITS > 20 ? TIMER_BITS : 20) + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REALARM    = 3'd0,
        CFG_AUTOSIL    = 3'd1,
        CFG_NOTE_GAP   = 3'd2,
        CFG_NOTE_LEN   = 3'd3,
        CFG_HIGH_NOTE  = 3'd4,
        CFG_LOW_NOTE   = 3'd5
    } cfg_index_t;

    localparam logic [19:0] REALARM_RESET   = 20'd60000;
    localparam logic [19:0] AUTOSIL_RESET   = 20'd300000;
    localparam logic [9:0]  NOTE_GAP_RESET  = 10'd220;
    localparam logic [9:0]  NOTE_LEN_RESET  = 10'd200;
    localparam logic [14:0] HIGH_NOTE_RESET = 15'd990;
    localparam logic [14:0] LOW_NOTE_RESET  = 15'd660;

    localparam logic [7:0] ELAPSED_LIMIT = 8'd200;

    localparam logic [1:0] NOTE_DONE = 2'd3;

    typedef struct packed {
        logic        armed;
        logic        silenced;
        logic        tone_on;
        logic [14:0] tone_hz;
        logic        acked_current;
        logic        ack_pulse;
        logic        wake_pulse;
    } result_t;

    function automatic logic [TIMER_BITS-1:0] timer_add(
        input logic [TIMER_BITS-1:0] t,
        input logic [7:0]            d
    );
        logic [TIMER_BITS:0] s;
        s = {1'b0, t} + (TIMER_BITS+1)'(d);
        timer_add = s[TIMER_BITS] ? '1 : s[TIMER_BITS-1:0];
    endfunction

endpackage

@@ rtl/eatc_tick_if.sv @@
`timescale 1ns / 1ps
// eatc_tick_if: input tick channel, valid/ready with tick fields
// no dependencies
interface eatc_tick_if;
    logic        valid;
    logic        ready;
    logic [7:0]  elapsed_ms;
    logic        alarm_wanted;
    logic [31:0] episode_id;
    logic        ack_request;

    modport source (output valid, elapsed_ms, alarm_wanted, episode_id, ack_request,
                    input ready);
    modport sink (input valid, elapsed_ms, alarm_wanted, episode_id, ack_request,
                  output ready);
endinterface

@@ rtl/eatc_result_if.sv @@
`timescale 1ns / 1ps
// eatc_result_if: result channel, valid/ready with result fields
// no dependencies
interface eatc_result_if;
    logic        valid;
    logic        ready;
    logic        armed;
    logic        silenced;
    logic        tone_on;
    logic [14:0] tone_hz;
    logic        acked_current;
    logic        ack_pulse;
    logic        wake_pulse;

    modport source (output valid, armed, silenced, tone_on, tone_hz, acked_current,
                    ack_pulse, wake_pulse, input ready);
    modport sink (input valid, armed, silenced, tone_on, tone_hz, acked_current,
                  ack_pulse, wake_pulse, output ready);
endinterface

@@ rtl/eatc_out_queue.sv @@
`timescale 1ns / 1ps
// eatc_out_queue: two-entry output register with skid slot
// depends on eatc_pkg and eatc_result_if
module eatc_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  eatc_pkg::result_t push_data,
    output logic             can_push,
    eatc_result_if.source    result
);
    import eatc_pkg::*;

    logic    head_valid_reg;
    logic    skid_valid_reg;
    result_t head_reg;
    result_t skid_reg;
    logic    pop;

    assign pop      = head_valid_reg && result.ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!push)
            begin
                head_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
            end
            else if (push)
            begin
                head_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

    assign result.valid         = head_valid_reg;
    assign result.armed         = head_reg.armed;
    assign result.silenced      = head_reg.silenced;
    assign result.tone_on       = head_reg.tone_on;
    assign result.tone_hz       = head_reg.tone_hz;
    assign result.acked_current = head_reg.acked_current;
    assign result.ack_pulse     = head_reg.ack_pulse;
    assign result.wake_pulse    = head_reg.wake_pulse;

endmodule

@@ rtl/episode_alarm_tone_controller.sv @@
`timescale 1ns / 1ps
// episode_alarm_tone_controller: top level, tick register, alarm state and note sequencer
// depends on eatc_pkg, eatc_tick_if, eatc_result_if, eatc_out_queue
//
// One result transaction per tick transaction. A tick is captured in an input register;
// when the queue can take a result, the alarm, timer and note logic updates all state and
// pushes the result into a two-entry output queue, so a tick can be taken on every clock
// while the queue has room. Ticks keep flowing while one result waits; the input stalls
// only when both queue entries are full. Configuration writes take effect immediately and
// belong in idle periods. Timers saturate at 2^TIMER_BITS-1 ms.
module episode_alarm_tone_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [eatc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eatc_pkg::CFG_DATA_W-1:0] cfg_data,
    eatc_tick_if.sink                       tick,
    eatc_result_if.source                   result
);
    import eatc_pkg::*;

    // configuration
    logic [19:0] realarm_reg;
    logic [19:0] autosil_reg;
    logic [9:0]  gap_reg;
    logic [9:0]  len_reg;
    logic [14:0] high_hz_reg;
    logic [14:0] low_hz_reg;

    // input register
    logic                    s1_valid_reg;
    logic [7:0]              s1_elapsed_reg;
    logic                    s1_want_reg;
    logic [EPISODE_BITS-1:0] s1_episode_reg;
    logic                    s1_ack_reg;

    // alarm state
    logic                    armed_reg,     armed_next;
    logic                    silenced_reg,  silenced_next;
    logic                    have_acked_reg, have_acked_next;
    logic [EPISODE_BITS-1:0] acked_ep_reg,  acked_ep_next;
    logic [1:0]              note_reg,      note_next;
    logic [TIMER_BITS-1:0]   raised_reg,    raised_next;
    logic [TIMER_BITS-1:0]   triad_reg,     triad_next;
    logic                    tone_on_reg,   tone_on_next;
    logic [14:0]             tone_hz_reg,   tone_hz_next;

    logic    can_push;
    logic    advance;
    result_t res;

    logic [7:0]       elapsed_c;
    logic             acked_this;
    logic [CMP_W-1:0] start_ofs;
    logic [CMP_W-1:0] stop_ofs;
    logic [CMP_W-1:0] since_ext;

    assign advance    = s1_valid_reg && can_push;
    assign tick.ready = !s1_valid_reg || can_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            realarm_reg <= REALARM_RESET;
            autosil_reg <= AUTOSIL_RESET;
            gap_reg     <= NOTE_GAP_RESET;
            len_reg     <= NOTE_LEN_RESET;
            high_hz_reg <= HIGH_NOTE_RESET;
            low_hz_reg  <= LOW_NOTE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_REALARM:   realarm_reg <= cfg_data;
                CFG_AUTOSIL:   autosil_reg <= cfg_data;
                CFG_NOTE_GAP:  gap_reg     <= cfg_data[9:0];
                CFG_NOTE_LEN:  len_reg     <= cfg_data[9:0];
                CFG_HIGH_NOTE: high_hz_reg <= cfg_data[14:0];
                CFG_LOW_NOTE:  low_hz_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            s1_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            s1_elapsed_reg <= tick.elapsed_ms;
            s1_want_reg    <= tick.alarm_wanted;
            s1_episode_reg <= tick.episode_id[EPISODE_BITS-1:0];
            s1_ack_reg     <= tick.ack_request;
        end
    end

    always_comb
    begin
        elapsed_c = (s1_elapsed_reg > ELAPSED_LIMIT) ? ELAPSED_LIMIT : s1_elapsed_reg;

        armed_next      = armed_reg;
        silenced_next   = silenced_reg;
        have_acked_next = have_acked_reg;
        acked_ep_next   = acked_ep_reg;
        note_next       = note_reg;
        tone_on_next    = tone_on_reg;
        tone_hz_next    = tone_hz_reg;
        raised_next     = timer_add(raised_reg, elapsed_c);
        triad_next      = timer_add(triad_reg, elapsed_c);
        res             = '0;

        // acknowledge
        if (s1_ack_reg && armed_reg)
        begin
            acked_ep_next   = s1_episode_reg;
            have_acked_next = 1'b1;
            armed_next      = 1'b0;
            silenced_next   = 1'b0;
            tone_on_next    = 1'b0;
            note_next       = NOTE_DONE;
            res.ack_pulse   = 1'b1;
        end

        acked_this = have_acked_next && (acked_ep_next == s1_episode_reg);

        // arm / disarm
        if (s1_want_reg)
        begin
            if (!acked_this && !armed_next)
            begin
                armed_next     = 1'b1;
                silenced_next  = 1'b0;
                raised_next    = '0;
                triad_next     = (CMP_W'(realarm_reg) > CMP_W'({TIMER_BITS{1'b1}}))
                               ? '1 : TIMER_BITS'(realarm_reg);
                res.wake_pulse = 1'b1;
            end
            if (acked_this)
            begin
                armed_next    = 1'b0;
                silenced_next = 1'b0;
            end
        end
        else
        begin
            if (armed_next)
            begin
                tone_on_next = 1'b0;
                note_next    = NOTE_DONE;
            end
            armed_next    = 1'b0;
            silenced_next = 1'b0;
        end

        // auto-silence and triad sequencer
        if (armed_next)
        begin
            if (!silenced_next && CMP_W'(raised_next) >= CMP_W'(autosil_reg))
            begin
                silenced_next = 1'b1;
                tone_on_next  = 1'b0;
                note_next     = NOTE_DONE;
            end
            if (!silenced_next)
            begin
                if (CMP_W'(triad_next) >= CMP_W'(realarm_reg))
                begin
                    triad_next = '0;
                    note_next  = 2'd0;
                end
                since_ext = CMP_W'(triad_next);
                case (note_next)
                    2'd0:    start_ofs = '0;
                    2'd1:    start_ofs = CMP_W'(gap_reg);
                    default: start_ofs = CMP_W'({gap_reg, 1'b0});
                endcase
                if (note_next != NOTE_DONE && since_ext >= start_ofs)
                begin
                    tone_on_next = 1'b1;
                    tone_hz_next = (note_next == 2'd1) ? low_hz_reg : high_hz_reg;
                    note_next    = note_next + 2'd1;
                end
                case (note_next)
                    2'd1:    stop_ofs = CMP_W'(len_reg);
                    2'd2:    stop_ofs = CMP_W'(gap_reg) + CMP_W'(len_reg);
                    default: stop_ofs = CMP_W'({gap_reg, 1'b0}) + CMP_W'(len_reg);
                endcase
                if (note_next != 2'd0 && since_ext >= stop_ofs)
                begin
                    tone_on_next = 1'b0;
                end
            end
            else
            begin
                since_ext = '0;
                start_ofs = '0;
                stop_ofs  = '0;
            end
        end
        else
        begin
            since_ext = '0;
            start_ofs = '0;
            stop_ofs  = '0;
        end

        res.armed         = armed_next;
        res.silenced      = silenced_next;
        res.tone_on       = tone_on_next;
        res.tone_hz       = tone_hz_next;
        res.acked_current = acked_this;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            silenced_reg   <= 1'b0;
            have_acked_reg <= 1'b0;
            acked_ep_reg   <= '0;
            note_reg       <= NOTE_DONE;
            raised_reg     <= '0;
            triad_reg      <= '0;
            tone_on_reg    <= 1'b0;
            tone_hz_reg    <= '0;
        end
        else if (advance)
        begin
            armed_reg      <= armed_next;
            silenced_reg   <= silenced_next;
            have_acked_reg <= have_acked_next;
            acked_ep_reg   <= acked_ep_next;
            note_reg       <= note_next;
            raised_reg     <= raised_next;
            triad_reg      <= triad_next;
            tone_on_reg    <= tone_on_next;
            tone_hz_reg    <= tone_hz_next;
        end
    end

    eatc_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (res),
        .can_push  (can_push),
        .result    (result)
    );

endmodule

@@ rtl/eatc_checker.sv @@
`timescale 1ns / 1ps
// eatc_checker: port-level assertions for the alarm tone controller, with bind
// depends on episode_alarm_tone_controller ports
module eatc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        armed,
    input logic        silenced,
    input logic        tone_on,
    input logic [14:0] tone_hz,
    input logic        acked_current,
    input logic        ack_pulse,
    input logic        wake_pulse
);

    a_wake_arms: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && wake_pulse |-> armed && !ack_pulse)
        else $error("wake pulse without armed alarm");

    a_ack_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ack_pulse |-> !armed && acked_current)
        else $error("ack pulse left alarm armed or episode unrecorded");

    a_silenced_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && silenced |-> armed && !tone_on)
        else $error("silenced while tone on or disarmed");

    a_acked_not_armed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && acked_current |-> !armed)
        else $error("acknowledged episode still armed");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(tone_hz) && $stable(armed)
            && $stable(tone_on) && $stable(wake_pulse) && $stable(ack_pulse))
        else $error("stalled result transaction changed");

endmodule

bind episode_alarm_tone_controller eatc_checker u_eatc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .armed         (result.armed),
    .silenced      (result.silenced),
    .tone_on       (result.tone_on),
    .tone_hz       (result.tone_hz),
    .acked_current (result.acked_current),
    .ack_pulse     (result.ack_pulse),
    .wake_pulse    (result.wake_pulse)
);
